@@ rtl/ppa_pkg.sv @@
package ppa_pkg;

  // Vertex coordinate width
  localparam int COORD_W = 16;

  // Serial multiplier: unsigned magnitudes, one radix-4 digit per step
  localparam int MUL_W      = COORD_W;
  localparam int MUL_DIGITS = MUL_W / 2;
  localparam int PROD_W     = 2 * MUL_W;

  // One edge's signed cross product x_a*y_b - x_b*y_a
  localparam int CROSS_W = PROD_W + 1;

  // dx*dx + dy*dy, then scaled by 2^(2*FRAC_W) for a Q8 root
  localparam int D2_W    = PROD_W + 1;
  localparam int FRAC_W  = 8;
  localparam int RAD_RAW = D2_W + 2 * FRAC_W;
  localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
  localparam int ROOT_W  = RAD_W / 2;

  // Accumulators and result fields
  localparam int CSUM_W      = 44;
  localparam int LSUM_W      = 36;
  localparam int PERIM_W     = 35;
  localparam int AREA_W      = 43;
  localparam int TOTAL_W     = 11;
  localparam int IN_TDATA_W  = 2 * COORD_W;
  localparam int OUT_RAW_W   = PERIM_W + AREA_W + TOTAL_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int MAX_VERTICES_DEF = 1024;

  // Polygon sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_CLOSE_GO,
    ST_CLOSE,
    ST_EMIT
  } state_t;

  // Edge engine request: start pulse with the edge's end points a -> b
  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } edge_req_t;

  // Edge engine response: done pulse with cross product and Q8 length
  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [CROSS_W-1:0] xprod;
    logic [ROOT_W-1:0]         len;
  } edge_rsp_t;

endpackage

@@ rtl/ppa_mul.sv @@
module ppa_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ppa_pkg::MUL_W-1:0]   a,
  input  logic [ppa_pkg::MUL_W-1:0]   b,
  output logic                        busy,
  output logic                        done,
  output logic [ppa_pkg::PROD_W-1:0]  prod
);

  localparam int CNT_W = $clog2(ppa_pkg::MUL_DIGITS);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [ppa_pkg::MUL_W-1:0] a_r;
  logic [ppa_pkg::MUL_W-1:0] hi_r;
  logic [ppa_pkg::MUL_W-1:0] lo_r;
  logic [ppa_pkg::MUL_W+1:0] pp;
  logic [ppa_pkg::MUL_W+1:0] sum;

  // a times the low digit of the multiplier, added into the high half
  always_comb begin
    pp  = ({2'b00, a_r} & {(ppa_pkg::MUL_W+2){lo_r[0]}})
        + ({1'b0, a_r, 1'b0} & {(ppa_pkg::MUL_W+2){lo_r[1]}});
    sum = {2'b00, hi_r} + pp;
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ppa_pkg::MUL_DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product shift register: low half takes two finished bits a step
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[ppa_pkg::MUL_W+1:2];
      lo_r <= {sum[1:0], lo_r[ppa_pkg::MUL_W-1:2]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

@@ rtl/ppa_sqrt.sv @@
module ppa_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ppa_pkg::RAD_W-1:0]   radicand,
  output logic                        busy,
  output logic                        done,
  output logic [ppa_pkg::ROOT_W-1:0]  root
);

  localparam int CNT_W = $clog2(ppa_pkg::ROOT_W);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [ppa_pkg::RAD_W-1:0]  rad_r;
  logic [ppa_pkg::ROOT_W:0]   rem_r;
  logic [ppa_pkg::ROOT_W:0]   rem_nxt;
  logic [ppa_pkg::ROOT_W-1:0] root_r;
  logic [ppa_pkg::ROOT_W-1:0] root_nxt;
  logic [ppa_pkg::ROOT_W+2:0] rem_sh;
  logic [ppa_pkg::ROOT_W+2:0] trial;
  logic [ppa_pkg::ROOT_W+2:0] diff;
  logic                       ge;

  // restoring recurrence: bring in two radicand bits, try 4*root+1
  always_comb begin
    rem_sh   = {rem_r, rad_r[ppa_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = rem_sh >= trial;
    diff     = rem_sh - trial;
    rem_nxt  = ge ? diff[ppa_pkg::ROOT_W:0] : rem_sh[ppa_pkg::ROOT_W:0];
    root_nxt = {root_r[ppa_pkg::ROOT_W-2:0], ge};
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ppa_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // radicand shifts out MSB pair first
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[ppa_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/ppa_edge.sv @@
module ppa_edge (
  input  logic               clk,
  input  logic               rst_n,
  input  ppa_pkg::edge_req_t req,
  output ppa_pkg::edge_rsp_t rsp
);

  // magnitude of a 17-bit two's complement value, fits 16 bits
  function automatic logic [ppa_pkg::COORD_W-1:0] mag(input logic [ppa_pkg::COORD_W:0] v);
    logic [ppa_pkg::COORD_W:0] n;
    n = -v;
    return v[ppa_pkg::COORD_W] ? n[ppa_pkg::COORD_W-1:0] : v[ppa_pkg::COORD_W-1:0];
  endfunction

  logic [ppa_pkg::COORD_W:0]   ax_e, ay_e, bx_e, by_e;
  logic [ppa_pkg::COORD_W:0]   dx, dy;
  logic [ppa_pkg::MUL_W-1:0]   dx_m, dy_m, ax_m, ay_m, bx_m, by_m;
  logic [ppa_pkg::PROD_W-1:0]  sq_x, sq_y, p1, p2;
  logic [ppa_pkg::D2_W-1:0]    d2;
  logic [ppa_pkg::RAD_W-1:0]   radicand;
  logic                        mul_busy, mul_done;
  logic                        sqrt_busy, sqrt_done;
  logic [ppa_pkg::ROOT_W-1:0]  root;
  logic                        neg1_r, neg2_r;
  logic signed [ppa_pkg::CROSS_W-1:0] t1, t2, v1, v2;
  logic signed [ppa_pkg::CROSS_W-1:0] cross_r;
  logic signed [ppa_pkg::CROSS_W-1:0] cross_nxt;

  // edge deltas and operand magnitudes
  always_comb begin
    ax_e = {req.ax[ppa_pkg::COORD_W-1], req.ax};
    ay_e = {req.ay[ppa_pkg::COORD_W-1], req.ay};
    bx_e = {req.bx[ppa_pkg::COORD_W-1], req.bx};
    by_e = {req.by[ppa_pkg::COORD_W-1], req.by};
    dx   = bx_e - ax_e;
    dy   = by_e - ay_e;
    dx_m = mag(dx);
    dy_m = mag(dy);
    ax_m = mag(ax_e);
    ay_m = mag(ay_e);
    bx_m = mag(bx_e);
    by_m = mag(by_e);
  end

  // four serial multipliers run in lockstep
  ppa_mul u_sq_x (
    .clk(clk), .rst_n(rst_n), .start(req.start), .a(dx_m), .b(dx_m),
    .busy(mul_busy), .done(mul_done), .prod(sq_x)
  );

  ppa_mul u_sq_y (
    .clk(clk), .rst_n(rst_n), .start(req.start), .a(dy_m), .b(dy_m),
    .busy(), .done(), .prod(sq_y)
  );

  ppa_mul u_p1 (
    .clk(clk), .rst_n(rst_n), .start(req.start), .a(ax_m), .b(by_m),
    .busy(), .done(), .prod(p1)
  );

  ppa_mul u_p2 (
    .clk(clk), .rst_n(rst_n), .start(req.start), .a(bx_m), .b(ay_m),
    .busy(), .done(), .prod(p2)
  );

  // product signs from the operand signs
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg1_r <= req.ax[ppa_pkg::COORD_W-1] ^ req.by[ppa_pkg::COORD_W-1];
      neg2_r <= req.bx[ppa_pkg::COORD_W-1] ^ req.ay[ppa_pkg::COORD_W-1];
    end
  end

  // signed cross product once the products are in
  always_comb begin
    t1        = $signed({1'b0, p1});
    t2        = $signed({1'b0, p2});
    v1        = neg1_r ? -t1 : t1;
    v2        = neg2_r ? -t2 : t2;
    cross_nxt = v1 - v2;
  end

  always_ff @(posedge clk) begin
    if (mul_done) begin
      cross_r <= cross_nxt;
    end
  end

  // squared length scaled to Q16 feeds the root unit
  assign d2       = {1'b0, sq_x} + {1'b0, sq_y};
  assign radicand = ppa_pkg::RAD_W'({d2, {(2 * ppa_pkg::FRAC_W){1'b0}}});

  ppa_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(mul_done), .radicand(radicand),
    .busy(sqrt_busy), .done(sqrt_done), .root(root)
  );

  assign rsp.busy  = mul_busy | mul_done | sqrt_busy | sqrt_done;
  assign rsp.done  = sqrt_done;
  assign rsp.xprod = cross_r;
  assign rsp.len   = root;

endmodule

@@ rtl/polygon_perimeter_area.sv @@
// Polygon perimeter and doubled area. Vertices arrive one per beat as signed
// 16-bit x/y with tlast on the polygon's final vertex; that beat yields one
// result: the closed perimeter in unsigned Q8 (each edge root rounded down),
// the exact doubled shoelace area, the vertex count and a flag for vertices
// dropped beyond MAX_VERTICES. Each edge runs through a digit-serial engine:
// 8 radix-4 multiply steps, then a 25-step bit-serial square root. A vertex
// that adds an edge holds in_tready low until the engine is done; the first
// vertex of a polygon, or a dropped one, starts no edge. The final vertex
// also runs the closing edge and the output load. A result in the output
// register holds off vertices only while the next result waits in ST_EMIT.
module polygon_perimeter_area #(
  parameter int MAX_VERTICES = ppa_pkg::MAX_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ppa_pkg::IN_TDATA_W-1:0]   in_tdata,   // vertex_x, vertex_y
  input  logic                             in_tlast,   // last_vertex
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ppa_pkg::OUT_TDATA_W-1:0]  out_tdata,  // perimeter_q8, doubled_area,
                                                       // vertex_total, zero pad
  output logic                             out_tuser   // too_many
);

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W = ppa_pkg::COORD_W;
  localparam int CSUM_W = ppa_pkg::CSUM_W;
  localparam int LSUM_W = ppa_pkg::LSUM_W;

  ppa_pkg::state_t    state_r, state_nxt;
  ppa_pkg::edge_req_t edge_req;
  ppa_pkg::edge_rsp_t edge_rsp;

  logic [CNT_W-1:0]          cnt_r;
  logic                      dropped_r;
  logic                      last_r;
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_W-1:0] in_x, in_y;
  logic [CSUM_W-1:0]         cross_sum_r, csum_nxt;
  logic [LSUM_W-1:0]         len_sum_r, lsum_nxt;
  logic [CSUM_W:0]           csum_ext;
  logic [LSUM_W:0]           lsum_ext;
  logic [CSUM_W-1:0]         area_mag;
  logic [ppa_pkg::PERIM_W-1:0] perim;
  logic [ppa_pkg::AREA_W-1:0]  area;
  logic [ppa_pkg::TOTAL_W+CNT_W-1:0] cnt_ext;
  logic                      out_valid_r;
  logic [ppa_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                      out_tuser_r;
  logic                      accept, cnt_zero, cnt_room, emit_go;

  assign in_x     = in_tdata[COORD_W-1:0];
  assign in_y     = in_tdata[2*COORD_W-1:COORD_W];
  assign accept   = in_tvalid && (state_r == ppa_pkg::ST_IDLE);
  assign cnt_zero = (cnt_r == '0);
  assign cnt_room = (cnt_r < CNT_W'(MAX_VERTICES));
  assign emit_go  = (state_r == ppa_pkg::ST_EMIT) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppa_pkg::ST_IDLE: begin
        if (accept) begin
          if (cnt_zero || !cnt_room) begin
            state_nxt = in_tlast ? ppa_pkg::ST_CLOSE_GO : ppa_pkg::ST_IDLE;
          end else begin
            state_nxt = ppa_pkg::ST_EDGE;
          end
        end
      end
      ppa_pkg::ST_EDGE: begin
        if (edge_rsp.done) begin
          state_nxt = last_r ? ppa_pkg::ST_CLOSE_GO : ppa_pkg::ST_IDLE;
        end
      end
      ppa_pkg::ST_CLOSE_GO: begin
        state_nxt = ppa_pkg::ST_CLOSE;
      end
      ppa_pkg::ST_CLOSE: begin
        if (edge_rsp.done) begin
          state_nxt = ppa_pkg::ST_EMIT;
        end
      end
      ppa_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ppa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppa_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs: ready and edge requests
  always_comb begin
    in_tready      = (state_r == ppa_pkg::ST_IDLE);
    edge_req.start = (accept && !cnt_zero && cnt_room)
                   || (state_r == ppa_pkg::ST_CLOSE_GO);
    edge_req.ax    = prev_x_r;
    edge_req.ay    = prev_y_r;
    edge_req.bx    = (state_r == ppa_pkg::ST_CLOSE_GO) ? first_x_r : in_x;
    edge_req.by    = (state_r == ppa_pkg::ST_CLOSE_GO) ? first_y_r : in_y;
  end

  ppa_edge u_edge (
    .clk(clk), .rst_n(rst_n), .req(edge_req), .rsp(edge_rsp)
  );

  // saturating accumulation of one finished edge
  always_comb begin
    csum_ext = {cross_sum_r[CSUM_W-1], cross_sum_r}
             + {{(CSUM_W + 1 - ppa_pkg::CROSS_W){edge_rsp.xprod[ppa_pkg::CROSS_W-1]}},
                edge_rsp.xprod};
    if (csum_ext[CSUM_W] != csum_ext[CSUM_W-1]) begin
      csum_nxt = csum_ext[CSUM_W] ? {1'b1, {(CSUM_W-1){1'b0}}}
                                  : {1'b0, {(CSUM_W-1){1'b1}}};
    end else begin
      csum_nxt = csum_ext[CSUM_W-1:0];
    end
    lsum_ext = {1'b0, len_sum_r} + (LSUM_W + 1)'(edge_rsp.len);
    lsum_nxt = lsum_ext[LSUM_W] ? {LSUM_W{1'b1}} : lsum_ext[LSUM_W-1:0];
  end

  // result fields, clamped to their widths
  always_comb begin
    perim    = (|len_sum_r[LSUM_W-1:ppa_pkg::PERIM_W]) ? {ppa_pkg::PERIM_W{1'b1}}
                                                      : len_sum_r[ppa_pkg::PERIM_W-1:0];
    area_mag = cross_sum_r[CSUM_W-1] ? -cross_sum_r : cross_sum_r;
    area     = area_mag[ppa_pkg::AREA_W] ? {ppa_pkg::AREA_W{1'b1}}
                                         : area_mag[ppa_pkg::AREA_W-1:0];
    cnt_ext  = {{ppa_pkg::TOTAL_W{1'b0}}, cnt_r};
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppa_pkg::ST_IDLE;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      last_r      <= 1'b0;
      cross_sum_r <= '0;
      len_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        last_r <= in_tlast;
        if (cnt_zero) begin
          cnt_r <= CNT_W'(1);
        end else if (cnt_room) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (edge_rsp.done) begin
        cross_sum_r <= csum_nxt;
        len_sum_r   <= lsum_nxt;
      end
      if (emit_go) begin
        cnt_r       <= '0;
        dropped_r   <= 1'b0;
        last_r      <= 1'b0;
        cross_sum_r <= '0;
        len_sum_r   <= '0;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // vertex store and output register
  always_ff @(posedge clk) begin
    if (accept && cnt_zero) begin
      first_x_r <= in_x;
      first_y_r <= in_y;
    end
    if (accept && cnt_room) begin
      prev_x_r <= in_x;
      prev_y_r <= in_y;
    end
    if (emit_go) begin
      out_tdata_r <= ppa_pkg::OUT_TDATA_W'({cnt_ext[ppa_pkg::TOTAL_W-1:0], area, perim});
      out_tuser_r <= dropped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  // a vertex is only taken with the edge engine quiet
  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !edge_rsp.busy)
    else $error("vertex accepted while edge engine busy");

  // edge results only arrive while the sequencer waits for them
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    edge_rsp.done |-> (state_r == ppa_pkg::ST_EDGE || state_r == ppa_pkg::ST_CLOSE))
    else $error("edge result outside an edge wait state");

  // accepted count never passes the limit
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond limit");

  // emitting a result clears the polygon and fills the output register
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (cnt_r == '0 && out_valid_r && len_sum_r == '0))
    else $error("polygon state not cleared after result");
`endif

endmodule
